>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the marquee scroller RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge out of reset.
`define MLS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define MLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mls_pkg.sv
// ----------------------------------------------------------------------------
// mls_pkg
// Types and codes for the marquee label scroller.
// ----------------------------------------------------------------------------
package mls_pkg;

    localparam int TEXT_W     = 13;
    localparam int X_W        = 15;
    localparam int DW_W       = 12;
    localparam int PAD_W      = 10;
    localparam int PAUSE_W    = 10;
    localparam int STEP_W     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // return move: distance / 8, at least 4 pixels
    localparam int RET_SHIFT    = 3;
    localparam int RET_MIN_STEP = 4;

    // operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // label phases
    localparam logic [2:0] PH_EMPTY      = 3'd0;
    localparam logic [2:0] PH_NEW        = 3'd1;
    localparam logic [2:0] PH_FIXED      = 3'd2;
    localparam logic [2:0] PH_WAIT_LEFT  = 3'd3;
    localparam logic [2:0] PH_SCROLL     = 3'd4;
    localparam logic [2:0] PH_WAIT_RIGHT = 3'd5;
    localparam logic [2:0] PH_RETURN     = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_PX   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PADDING     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAUSE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_PAUSE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_STEP = 3'd4;

    // configuration reset values
    localparam logic [DW_W-1:0]    RST_SCREEN_PX   = 12'd240;
    localparam logic [PAD_W-1:0]   RST_PADDING     = 10'd25;
    localparam logic [PAUSE_W-1:0] RST_FIRST_PAUSE = 10'd30;
    localparam logic [PAUSE_W-1:0] RST_END_PAUSE   = 10'd60;
    localparam logic [STEP_W-1:0]  RST_SCROLL_STEP = 6'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [TEXT_W-1:0] text_px;
    } t_in_item;

    typedef struct packed {
        logic signed [X_W-1:0] x_pos;
        logic                  draw;
        logic                  scrolling;
    } t_out_item;

    typedef struct packed {
        logic [DW_W-1:0]    screen_px;
        logic [PAD_W-1:0]   padding;
        logic [PAUSE_W-1:0] first_pause;
        logic [PAUSE_W-1:0] end_pause;
        logic [STEP_W-1:0]  scroll_step;
    } t_cfg;

endpackage

>>> rtl/mls_engine.sv
// ----------------------------------------------------------------------------
// mls_engine
// Label state and the per-item update: placement, waits, scroll and return.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mls_engine #(
    parameter int WIDTH_BITS = 13
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  mls_pkg::t_in_item   i_item,
    input  mls_pkg::t_cfg       i_cfg,
    output mls_pkg::t_out_item  o_result
);

    // position width: room for display - label - padding minus one step
    localparam int XW = (WIDTH_BITS > 10) ? WIDTH_BITS + 6 : 16;

    logic [2:0]                          r_phase, n_phase;
    logic [WIDTH_BITS-1:0]               r_label_width, n_label_width;
    logic signed [XW-1:0]                r_cur_x, n_cur_x;
    logic signed [XW-1:0]                r_home_x, n_home_x;
    logic signed [XW-1:0]                r_far_x, n_far_x;
    logic [mls_pkg::PAUSE_W-1:0]         r_wait_count, n_wait_count;

    logic [WIDTH_BITS+mls_pkg::TEXT_W-1:0] text_ext;
    logic signed [XW-1:0] dw_s, pad_s, w_s, step_s, min_step_s;
    logic signed [XW-1:0] centre, start_x, scroll_x, ret_dist, ret_delta, ret_x;
    logic                 draw;
    logic                 load_fire, at_new, in_scroll, x_bounded;

    assign text_ext   = {{WIDTH_BITS{1'b0}}, i_item.text_px};
    assign dw_s       = signed'(XW'(i_cfg.screen_px));
    assign pad_s      = signed'(XW'(i_cfg.padding));
    assign w_s        = signed'(XW'(r_label_width));
    assign step_s     = signed'(XW'(i_cfg.scroll_step));
    assign min_step_s = signed'(XW'(mls_pkg::RET_MIN_STEP));

    assign centre   = (dw_s >= w_s) ? ((dw_s - w_s) >>> 1) : '0;
    assign start_x  = (centre > pad_s) ? centre : pad_s;
    assign scroll_x = r_cur_x - step_s;

    always_comb begin
        ret_dist = r_cur_x - r_home_x;
        if (ret_dist < 0) begin
            ret_dist = -ret_dist;
        end
        ret_delta = ret_dist >>> mls_pkg::RET_SHIFT;
        if (ret_delta < min_step_s) begin
            ret_delta = min_step_s;
        end
        ret_x = r_cur_x + ret_delta;
    end

    always_comb begin
        n_phase       = r_phase;
        n_label_width = r_label_width;
        n_cur_x       = r_cur_x;
        n_home_x      = r_home_x;
        n_far_x       = r_far_x;
        n_wait_count  = r_wait_count;
        draw          = 1'b0;
        unique case (i_item.op)
            mls_pkg::OP_TICK: begin
                unique case (r_phase) inside
                    mls_pkg::PH_NEW: begin
                        n_home_x = start_x;
                        n_cur_x  = start_x;
                        draw     = 1'b1;
                        if (w_s > dw_s - (pad_s <<< 1)) begin
                            n_far_x      = dw_s - w_s - pad_s;
                            n_phase      = mls_pkg::PH_WAIT_LEFT;
                            n_wait_count = i_cfg.first_pause;
                        end else begin
                            n_phase = mls_pkg::PH_FIXED;
                        end
                    end
                    mls_pkg::PH_WAIT_LEFT, mls_pkg::PH_WAIT_RIGHT: begin
                        if (r_wait_count != '0) begin
                            n_wait_count = r_wait_count - 1'b1;
                        end else if (r_phase == mls_pkg::PH_WAIT_LEFT) begin
                            n_phase = mls_pkg::PH_SCROLL;
                        end else begin
                            n_phase = mls_pkg::PH_RETURN;
                        end
                    end
                    mls_pkg::PH_SCROLL: begin
                        draw = 1'b1;
                        if (scroll_x <= r_far_x) begin
                            n_cur_x      = r_far_x;
                            n_phase      = mls_pkg::PH_WAIT_RIGHT;
                            n_wait_count = i_cfg.end_pause;
                        end else begin
                            n_cur_x = scroll_x;
                        end
                    end
                    mls_pkg::PH_RETURN: begin
                        draw = 1'b1;
                        if (ret_x >= r_home_x) begin
                            n_cur_x      = r_home_x;
                            n_phase      = mls_pkg::PH_WAIT_LEFT;
                            n_wait_count = i_cfg.end_pause;
                        end else begin
                            n_cur_x = ret_x;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            mls_pkg::OP_LOAD: begin
                n_label_width = text_ext[WIDTH_BITS-1:0];
                n_phase       = mls_pkg::PH_NEW;
                n_wait_count  = '0;
            end
            mls_pkg::OP_CLEAR: begin
                n_phase = mls_pkg::PH_EMPTY;
            end
            default: begin
            end
        endcase
    end

    // result reflects the state left by this item
    always_comb begin
        o_result.x_pos     = (n_phase == mls_pkg::PH_EMPTY) ? '0 : n_cur_x[mls_pkg::X_W-1:0];
        o_result.draw      = draw;
        o_result.scrolling = (n_phase >= mls_pkg::PH_WAIT_LEFT) &&
                             (n_phase <= mls_pkg::PH_RETURN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= mls_pkg::PH_EMPTY;
            r_label_width <= '0;
            r_cur_x       <= '0;
            r_home_x      <= '0;
            r_far_x       <= '0;
            r_wait_count  <= '0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_label_width <= n_label_width;
            r_cur_x       <= n_cur_x;
            r_home_x      <= n_home_x;
            r_far_x       <= n_far_x;
            r_wait_count  <= n_wait_count;
        end
    end

    assign load_fire = i_fire && (i_item.op == mls_pkg::OP_LOAD);
    assign at_new    = (r_phase == mls_pkg::PH_NEW);
    assign in_scroll = (r_phase >= mls_pkg::PH_WAIT_LEFT) && (r_phase <= mls_pkg::PH_RETURN);
    assign x_bounded = (r_cur_x <= r_home_x) && (r_cur_x >= r_far_x);

    `MLS_ASSERT_NEXT(a_load_restarts, i_clk, i_rst_n, load_fire, at_new, "load ignored")
    `MLS_ASSERT(a_x_in_range, i_clk, i_rst_n, !in_scroll || x_bounded, "x out of range")

endmodule

>>> rtl/marquee_label_scroller.sv
// ----------------------------------------------------------------------------
// marquee_label_scroller
// Horizontal marquee control for one text label.
//
// Input channel (i_in_valid / o_in_stall, i_in_data): one transfer per op:
// tick, load label width, or clear. Every transfer yields one result on the
// output channel (o_out_valid / i_out_stall, o_out_data): x position, redraw
// flag and scrolling flag. Registers are written on the cfg channel
// (i_cfg_valid / o_cfg_ready), which is always ready; write them while idle.
// Each item passes through the input register, then the label state update
// into the result register. Throughput is one item per cycle while i_out_stall
// stays low, bounded by the state update loop.
// Reset loads the register defaults and leaves no label shown.
// While i_out_stall holds a waiting result, the input register still takes
// one more item; after that o_in_stall rises until the result moves on.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module marquee_label_scroller #(
    parameter int WIDTH_BITS = 13
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  mls_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output mls_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mls_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mls_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic               r_in_valid;
    mls_pkg::t_in_item  r_in_data;
    logic               r_out_valid;
    mls_pkg::t_out_item r_out_data;
    mls_pkg::t_cfg      r_cfg;
    mls_pkg::t_out_item result;
    logic               out_free;
    logic               out_held;
    logic               fire;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign out_held    = r_out_valid && i_out_stall;
    assign fire        = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_px   <= mls_pkg::RST_SCREEN_PX;
            r_cfg.padding     <= mls_pkg::RST_PADDING;
            r_cfg.first_pause <= mls_pkg::RST_FIRST_PAUSE;
            r_cfg.end_pause   <= mls_pkg::RST_END_PAUSE;
            r_cfg.scroll_step <= mls_pkg::RST_SCROLL_STEP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mls_pkg::CFG_SCREEN_PX:
                    r_cfg.screen_px <= i_cfg_data[mls_pkg::DW_W-1:0];
                mls_pkg::CFG_PADDING:
                    r_cfg.padding <= i_cfg_data[mls_pkg::PAD_W-1:0];
                mls_pkg::CFG_FIRST_PAUSE:
                    r_cfg.first_pause <= i_cfg_data[mls_pkg::PAUSE_W-1:0];
                mls_pkg::CFG_END_PAUSE:
                    r_cfg.end_pause <= i_cfg_data[mls_pkg::PAUSE_W-1:0];
                mls_pkg::CFG_SCROLL_STEP:
                    r_cfg.scroll_step <= i_cfg_data[mls_pkg::STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register: take a new transfer whenever it is empty or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    mls_engine #(
        .WIDTH_BITS (WIDTH_BITS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_data),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= result;
        end
    end

    `MLS_ASSERT(a_stall_only_when_full, i_clk, i_rst_n, !o_in_stall || out_held, "stall with room")
    `MLS_ASSERT_NEXT(a_fire_fills_output, i_clk, i_rst_n, fire, r_out_valid, "no result for item")

endmodule

>>> sim/marquee_label_scroller_tb.sv
// ----------------------------------------------------------------------------
// marquee_label_scroller_tb
// Self-checking bench for the marquee label scroller. A short directed table
// walks reset behavior, field extremes, every op, reload and clear mid-scroll,
// a zero step and a zero screen width. Random traffic then runs under several
// register settings with random idling on both channels, a long output
// hold-off and a full drain. Every result is checked against a cycle-free
// model of the label sequence or against the row's expected value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module marquee_label_scroller_tb;

    localparam int TEXT_W     = mls_pkg::TEXT_W;
    localparam int X_W        = mls_pkg::X_W;
    localparam int CFG_IDX_W  = mls_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = mls_pkg::CFG_DATA_W;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int IDLE_PCT     = 27;
    localparam int HOLD_CYCLES  = 48;
    localparam int QUIET_LIMIT  = 1000;
    localparam int NUM_PHASES   = 7;
    localparam int STEADY_PHASE = 3;
    localparam int HOLD_PHASE   = 4;
    localparam int DRAIN_PHASE  = 6;
    localparam int MAX_PRINTS   = 100;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    mls_pkg::t_in_item     i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    mls_pkg::t_out_item    o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    marquee_label_scroller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // register settings per random phase: width, padding, first, end, step
    int cfg_table [NUM_PHASES][5] = '{
        '{240,  25,    3,    4,  2},
        '{4095, 1023,  0,    0,  63},
        '{1,    0,     1023, 1023, 1},
        '{320,  10,    5,    2,  7},
        '{128,  0,     0,    1,  1},
        '{240,  25,    30,   60, 2},
        '{800,  200,   2,    3,  33}
    };
    int phase_items [NUM_PHASES] = '{120, 110, 40, 120, 120, 120, 120};

    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        int                   reg_val;
        mls_pkg::t_in_item    item;
        bit                   typed;
        mls_pkg::t_out_item   want;
    } t_dir_row;

    t_dir_row           dir_rows[$];
    mls_pkg::t_out_item queued_positions[$];

    // label model state and its copy of the registers
    logic [2:0] lbl_phase = mls_pkg::PH_EMPTY;
    int lbl_width = 0;
    int cur_x     = 0;
    int home_x    = 0;
    int far_x     = 0;
    int wait_left = 0;
    int cfg_dw    = mls_pkg::RST_SCREEN_PX;
    int cfg_pad   = mls_pkg::RST_PADDING;
    int cfg_first = mls_pkg::RST_FIRST_PAUSE;
    int cfg_end   = mls_pkg::RST_END_PAUSE;
    int cfg_step  = mls_pkg::RST_SCROLL_STEP;

    bit steady    = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int errors        = 0;
    int items_in      = 0;
    int checked_count = 0;
    int reg_writes    = 0;
    int quiet_cycles  = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic mls_pkg::t_out_item step_marquee(input mls_pkg::t_in_item item);
        mls_pkg::t_out_item res;
        int centre;
        int ret_dist;
        int delta;
        logic drew;
        drew = 1'b0;
        case (item.op)
            mls_pkg::OP_TICK: begin
                case (lbl_phase) inside
                    mls_pkg::PH_NEW: begin
                        centre = (cfg_dw >= lbl_width) ? (cfg_dw - lbl_width) / 2 : 0;
                        home_x = (centre > cfg_pad) ? centre : cfg_pad;
                        cur_x  = home_x;
                        if (lbl_width > cfg_dw - 2 * cfg_pad) begin
                            far_x     = cfg_dw - lbl_width - cfg_pad;
                            lbl_phase = mls_pkg::PH_WAIT_LEFT;
                            wait_left = cfg_first;
                        end else begin
                            lbl_phase = mls_pkg::PH_FIXED;
                        end
                        drew = 1'b1;
                    end
                    mls_pkg::PH_WAIT_LEFT, mls_pkg::PH_WAIT_RIGHT: begin
                        if (wait_left != 0) begin
                            wait_left--;
                        end else if (lbl_phase == mls_pkg::PH_WAIT_LEFT) begin
                            lbl_phase = mls_pkg::PH_SCROLL;
                        end else begin
                            lbl_phase = mls_pkg::PH_RETURN;
                        end
                    end
                    mls_pkg::PH_SCROLL: begin
                        cur_x = cur_x - cfg_step;
                        drew  = 1'b1;
                        if (cur_x <= far_x) begin
                            cur_x     = far_x;
                            lbl_phase = mls_pkg::PH_WAIT_RIGHT;
                            wait_left = cfg_end;
                        end
                    end
                    mls_pkg::PH_RETURN: begin
                        ret_dist = cur_x - home_x;
                        if (ret_dist < 0) begin
                            ret_dist = -ret_dist;
                        end
                        delta = ret_dist / (1 << mls_pkg::RET_SHIFT);
                        if (delta < mls_pkg::RET_MIN_STEP) begin
                            delta = mls_pkg::RET_MIN_STEP;
                        end
                        cur_x = cur_x + delta;
                        drew  = 1'b1;
                        if (cur_x >= home_x) begin
                            cur_x     = home_x;
                            lbl_phase = mls_pkg::PH_WAIT_LEFT;
                            wait_left = cfg_end;
                        end
                    end
                    default: ;
                endcase
            end
            mls_pkg::OP_LOAD: begin
                lbl_width = item.text_px;
                lbl_phase = mls_pkg::PH_NEW;
                wait_left = 0;
            end
            mls_pkg::OP_CLEAR: lbl_phase = mls_pkg::PH_EMPTY;
            default: ;
        endcase
        res.x_pos     = (lbl_phase == mls_pkg::PH_EMPTY) ? '0 : X_W'(cur_x);
        res.draw      = drew;
        res.scrolling = (lbl_phase >= mls_pkg::PH_WAIT_LEFT) &&
                        (lbl_phase <= mls_pkg::PH_RETURN);
        return res;
    endfunction

    function automatic void add_item(input logic [1:0] op, input int tw, input bit typed = 0,
                                     input int x = 0, input bit d = 0, input bit s = 0);
        t_dir_row row;
        row.is_reg         = 1'b0;
        row.reg_idx        = '0;
        row.reg_val        = 0;
        row.item.op        = op;
        row.item.text_px   = TEXT_W'(tw);
        row.typed          = typed;
        row.want.x_pos     = X_W'(x);
        row.want.draw      = d;
        row.want.scrolling = s;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        t_dir_row row;
        row        = '{default: 0};
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = value;
        dir_rows.push_back(row);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_PRINTS) begin
            $display("mismatch %s: got %0d, expected %0d (result %0d)",
                     what, got, want, checked_count);
        end
    endtask

    // hold the payload until the transfer, then log its expected result
    task automatic send_item(input mls_pkg::t_in_item item, input bit typed,
                             input mls_pkg::t_out_item want);
        int gap;
        mls_pkg::t_out_item predicted;
        gap = 0;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        predicted = step_marquee(item);
        queued_positions.push_back(typed ? want : predicted);
        items_in++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (queued_positions.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            mls_pkg::CFG_SCREEN_PX:   cfg_dw    = value & 'hFFF;
            mls_pkg::CFG_PADDING:     cfg_pad   = value & 'h3FF;
            mls_pkg::CFG_FIRST_PAUSE: cfg_first = value & 'h3FF;
            mls_pkg::CFG_END_PAUSE:   cfg_end   = value & 'h3FF;
            mls_pkg::CFG_SCROLL_STEP: cfg_step  = value & 'h3F;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic run_phase(input int p);
        mls_pkg::t_in_item item;
        mls_pkg::t_out_item none;
        int r;
        int base;
        int tw;
        none = '0;
        steady <= (p == STEADY_PHASE);
        drain();
        write_reg(mls_pkg::CFG_SCREEN_PX,   cfg_table[p][0]);
        write_reg(mls_pkg::CFG_PADDING,     cfg_table[p][1]);
        write_reg(mls_pkg::CFG_FIRST_PAUSE, cfg_table[p][2]);
        write_reg(mls_pkg::CFG_END_PAUSE,   cfg_table[p][3]);
        write_reg(mls_pkg::CFG_SCROLL_STEP, cfg_table[p][4]);
        for (int n = 0; n < phase_items[p]; n++) begin
            if (p == HOLD_PHASE && n == 30) begin
                hold_req <= 1'b1;
            end
            if (p == DRAIN_PHASE && n == 50) begin
                drain();
            end
            r  = $urandom_range(0, 99);
            tw = $urandom_range(0, (1 << TEXT_W) - 1);
            if (r < 5) begin
                item.op = mls_pkg::OP_LOAD;
                // bias widths toward the scroll threshold to get short cycles
                base = cfg_dw - 2 * cfg_pad;
                case ($urandom_range(0, 3))
                    1: tw = base + $urandom_range(0, 40) - 20;
                    2: tw = base + $urandom_range(1, 300);
                    3: tw = $urandom_range(0, cfg_dw);
                    default: ;
                endcase
                if (tw < 0) begin
                    tw = 0;
                end else if (tw >= (1 << TEXT_W)) begin
                    tw = (1 << TEXT_W) - 1;
                end
            end else if (r < 7) begin
                item.op = mls_pkg::OP_CLEAR;
            end else if (r < 9) begin
                item.op = OP_UNUSED;
            end else begin
                item.op = mls_pkg::OP_TICK;
            end
            item.text_px = TEXT_W'(tw);
            send_item(item, 1'b0, none);
        end
    endtask

    // directed rows first, then the random phases
    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;

        add_item(mls_pkg::OP_TICK,  0, 1, 0, 0, 0);
        add_item(OP_UNUSED,         0, 1, 0, 0, 0);
        add_item(mls_pkg::OP_LOAD,  0, 1, 0, 0, 0);
        add_item(mls_pkg::OP_TICK,  8191);
        add_item(mls_pkg::OP_TICK,  0);
        add_item(OP_UNUSED,         8191);
        add_item(mls_pkg::OP_CLEAR, 0, 1, 0, 0, 0);
        add_item(mls_pkg::OP_TICK,  0, 1, 0, 0, 0);
        add_item(mls_pkg::OP_LOAD,  8191);
        add_item(mls_pkg::OP_TICK,  0, 1, 25, 1, 1);
        add_item(mls_pkg::OP_LOAD,  240);
        add_reg(mls_pkg::CFG_FIRST_PAUSE, 0);
        add_reg(mls_pkg::CFG_END_PAUSE,   0);
        add_reg(mls_pkg::CFG_SCROLL_STEP, 63);
        add_item(mls_pkg::OP_TICK,  0);
        add_item(mls_pkg::OP_TICK,  0);
        add_item(mls_pkg::OP_TICK,  0);
        add_item(mls_pkg::OP_TICK,  0);
        add_item(mls_pkg::OP_TICK,  0);
        add_item(OP_UNUSED,         0);
        add_item(mls_pkg::OP_CLEAR, 0, 1, 0, 0, 0);
        // zero step: stuck scrolling left, redrawn on every scroll tick
        add_reg(mls_pkg::CFG_SCROLL_STEP, 0);
        add_item(mls_pkg::OP_LOAD,  300);
        add_item(mls_pkg::OP_TICK,  0);
        add_item(mls_pkg::OP_TICK,  0);
        add_item(mls_pkg::OP_TICK,  0);
        add_item(mls_pkg::OP_TICK,  0);
        add_reg(mls_pkg::CFG_SCREEN_PX, 0);
        add_item(mls_pkg::OP_LOAD,  5);
        add_item(mls_pkg::OP_TICK,  0);
        add_item(mls_pkg::OP_TICK,  0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_reg) begin
                drain();
                write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_val);
            end else begin
                send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            run_phase(p);
        end

        drain();
        repeat (8) @(posedge i_clk);
        while (queued_positions.size() != 0) begin
            report_mismatch("missing result, x_pos", 0, queued_positions.pop_front().x_pos);
        end
        $display("sent %0d items, checked %0d results, %0d register writes, %0d settings",
                 items_in, checked_count, reg_writes, NUM_PHASES + 1);
        $display("covered fixed, scrolling, cleared and reloaded labels; %0d mismatches",
                 errors);
        if (errors == 0) begin
            $display("PASS marquee_label_scroller");
        end else begin
            $display("FAIL marquee_label_scroller");
        end
        $finish;
    end

    // output side: random stall, plus one long hold-off to back up the input
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        mls_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (queued_positions.size() == 0) begin
                report_mismatch("unexpected result, x_pos", $signed(o_out_data.x_pos), 0);
            end else begin
                want = queued_positions.pop_front();
                if (o_out_data.x_pos !== want.x_pos) begin
                    report_mismatch("x_pos", $signed(o_out_data.x_pos), $signed(want.x_pos));
                end
                if (o_out_data.draw !== want.draw) begin
                    report_mismatch("draw", o_out_data.draw, want.draw);
                end
                if (o_out_data.scrolling !== want.scrolling) begin
                    report_mismatch("scrolling", o_out_data.scrolling, want.scrolling);
                end
            end
            checked_count++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("FAIL marquee_label_scroller");
            $finish;
        end
    end

endmodule
